// File: hdl/assert_macros.svh
// Assertion macros used by the checker module of the line follower.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle implication failed.");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle implication failed.");

`endif

// File: hdl/lfs_pkg.sv
// Package for the line follower steering block: sizes, register indexes, state type
// and the sensor weight function. No dependencies.
`timescale 1ns / 1ps

package lfs_pkg;

   localparam int SENSOR_COUNT    = 8;
   localparam int SAMPLE_BITS     = 10;
   localparam int SENSOR_IDX_BITS = $clog2(SENSOR_COUNT);
   localparam int WEIGHT_BITS     = 10;
   localparam int TOTAL_BITS      = 13;
   localparam int WSUM_BITS       = 21;
   localparam int MAG_BITS        = WSUM_BITS - 1;
   localparam int QUOT_BITS       = 9;
   localparam int DIV_CNT_BITS    = $clog2(QUOT_BITS);
   localparam int POS_BITS        = 10;
   localparam int SPEED_BITS      = 8;
   localparam int COUNT_BITS      = 4;
   localparam int CORR_BITS       = 15;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 13;

   localparam logic [COUNT_BITS-1:0] LOSS_MAX  = 4'd15;
   localparam logic [SPEED_BITS-1:0] SPEED_MAX = 8'd255;

   localparam logic [CSR_INDEX_BITS-1:0] REG_THRESHOLD   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LEFT_BASE   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RIGHT_BASE  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SEARCH_SPIN = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_SIGNAL  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_ACTIVE  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOST_LIMIT  = 3'd7;

   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET   = 10'd800;
   localparam logic [SPEED_BITS-1:0]  GAIN_RESET        = 8'd48;
   localparam logic [SPEED_BITS-1:0]  LEFT_BASE_RESET   = 8'd200;
   localparam logic [SPEED_BITS-1:0]  RIGHT_BASE_RESET  = 8'd200;
   localparam logic [SPEED_BITS-1:0]  SEARCH_SPIN_RESET = 8'd120;
   localparam logic [TOTAL_BITS-1:0]  MIN_SIGNAL_RESET  = 13'd50;
   localparam logic [COUNT_BITS-1:0]  MIN_ACTIVE_RESET  = 4'd6;
   localparam logic [COUNT_BITS-1:0]  LOST_LIMIT_RESET  = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_SETUP,
      ST_DIVIDE,
      ST_SCALE,
      ST_DONE
   } state_type;

   // Sensor weight: 100 per position step, centered on the middle of the array.
   function automatic logic signed [WEIGHT_BITS-1:0] weight_of(
      input logic [SENSOR_IDX_BITS-1:0] idx);
      return WEIGHT_BITS'(100 * int'(idx) - 50 * (SENSOR_COUNT - 1));
   endfunction

endpackage

// File: hdl/line_follow_steering.sv
// Line follower steering: weighted centroid, serial division and proportional drive.
// Depends on lfs_pkg.
`timescale 1ns / 1ps
//
//   channel | direction | ports                               | transfer when
//   req     | in        | req_valid/req_ready, req_sample_0-7 | req_valid && req_ready
//   rsp     | out       | rsp_valid/rsp_ready, 7 fields       | rsp_valid && rsp_ready
//   csr     | in        | csr_we, csr_index, csr_wdata        | csr_we
//
// An item passes from transfer to result through accumulation over the eight sensors,
// setup, nine divider steps, gain scaling and the load of the output register; the divider
// steps are skipped when the line is lost or the total is zero.
// The next item is taken the cycle after its result is loaded, even if that result waits,
// so a new item is accepted only once the last one has gone to the output register.
// Reset is synchronous and restores the configuration, control and tracking registers.
// A stalled result holds the block in its final step until the output register frees.

module line_follow_steering (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lfs_pkg::SAMPLE_BITS-1:0]   req_sample_0,
   input  logic [lfs_pkg::SAMPLE_BITS-1:0]   req_sample_1,
   input  logic [lfs_pkg::SAMPLE_BITS-1:0]   req_sample_2,
   input  logic [lfs_pkg::SAMPLE_BITS-1:0]   req_sample_3,
   input  logic [lfs_pkg::SAMPLE_BITS-1:0]   req_sample_4,
   input  logic [lfs_pkg::SAMPLE_BITS-1:0]   req_sample_5,
   input  logic [lfs_pkg::SAMPLE_BITS-1:0]   req_sample_6,
   input  logic [lfs_pkg::SAMPLE_BITS-1:0]   req_sample_7,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lfs_pkg::SPEED_BITS-1:0]    rsp_left_speed,
   output logic [lfs_pkg::SPEED_BITS-1:0]    rsp_right_speed,
   output logic signed [lfs_pkg::POS_BITS-1:0] rsp_position,
   output logic                              rsp_line_lost,
   output logic [lfs_pkg::COUNT_BITS-1:0]    rsp_active_count,
   output logic                              rsp_at_intersection,
   output logic                              rsp_line_ended,
   input  logic                              csr_we,
   input  logic [lfs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lfs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   import lfs_pkg::*;

   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] threshold_ff;
   logic [SPEED_BITS-1:0]  gain_ff, left_base_ff, right_base_ff, search_spin_ff;
   logic [TOTAL_BITS-1:0]  min_signal_ff;
   logic [COUNT_BITS-1:0]  min_active_ff, lost_limit_ff;

   logic signed [POS_BITS-1:0] last_pos_ff;
   logic [COUNT_BITS-1:0]      loss_run_ff;

   logic [SAMPLE_BITS-1:0]     samp_ff [SENSOR_COUNT];
   logic [SENSOR_IDX_BITS-1:0] acc_idx_ff;
   logic [TOTAL_BITS-1:0]      total_ff;
   logic signed [WSUM_BITS-1:0] wsum_ff;
   logic [COUNT_BITS-1:0]      active_ff;
   logic                       lost_ff;
   logic                       sign_ff;
   logic [TOTAL_BITS-1:0]      rem_ff;
   logic [QUOT_BITS-1:0]       dq_ff;
   logic [DIV_CNT_BITS-1:0]    div_cnt_ff;
   logic signed [POS_BITS-1:0] pos_ff;
   logic signed [CORR_BITS-1:0] corr_ff;

   logic                       rsp_valid_ff;
   logic [SPEED_BITS-1:0]      left_ff, right_ff;
   logic signed [POS_BITS-1:0] position_ff;
   logic                       line_lost_ff, at_int_ff, line_ended_ff;
   logic [COUNT_BITS-1:0]      active_out_ff;

   logic accept, acc_last, div_last, rsp_load;

   logic [SAMPLE_BITS-1:0]      head_v;
   logic                        head_active;
   logic signed [WSUM_BITS-1:0] head_prod;
   logic                        total_low;
   logic [WSUM_BITS-1:0]        wsum_abs;
   logic [TOTAL_BITS:0]         trial;
   logic                        trial_ge;
   logic signed [POS_BITS-1:0]  pos_new;
   logic signed [POS_BITS+SPEED_BITS:0] scaled;
   logic signed [POS_BITS+SPEED_BITS:0] scaled_adj;
   logic signed [CORR_BITS-1:0] spin_ext, offset;
   logic signed [CORR_BITS-1:0] left_raw, right_raw;
   logic [SPEED_BITS-1:0]       left_clamp, right_clamp;
   logic [COUNT_BITS-1:0]       loss_run_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_ACCUM;
         ST_ACCUM:  if (acc_last) state_in = ST_SETUP;
         ST_SETUP:  state_in = (total_low || total_ff == '0) ? ST_SCALE : ST_DIVIDE;
         ST_DIVIDE: if (div_last) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DONE: rsp_load  = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            rsp_load  = 1'b0;
         end
      endcase
   end

   assign accept   = req_valid && req_ready;
   assign acc_last = acc_idx_ff == SENSOR_IDX_BITS'(SENSOR_COUNT - 1);
   assign div_last = div_cnt_ff == DIV_CNT_BITS'(QUOT_BITS - 1);

   // One sensor per cycle from the head of the sample shift register.
   assign head_active = samp_ff[0] > threshold_ff;
   assign head_v      = head_active ? samp_ff[0] - threshold_ff : '0;
   assign head_prod   = $signed({1'b0, head_v}) * weight_of(acc_idx_ff);

   assign total_low = total_ff < min_signal_ff;
   assign wsum_abs  = wsum_ff[WSUM_BITS-1] ? WSUM_BITS'(-wsum_ff) : wsum_ff;

   // One restoring division step per cycle; the quotient shifts in as the dividend leaves.
   assign trial    = {rem_ff, dq_ff[QUOT_BITS-1]};
   assign trial_ge = trial >= {1'b0, total_ff};

   assign pos_new    = sign_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
   assign scaled     = pos_new * $signed({1'b0, gain_ff});
   assign scaled_adj = scaled[POS_BITS+SPEED_BITS] ? scaled + (POS_BITS+SPEED_BITS+1)'(15)
                                                   : scaled;

   assign spin_ext = $signed(CORR_BITS'(search_spin_ff));
   assign offset   = lost_ff ? (last_pos_ff[POS_BITS-1] ? -spin_ext : spin_ext) : corr_ff;
   assign left_raw  = $signed(CORR_BITS'(left_base_ff)) - offset;
   assign right_raw = $signed(CORR_BITS'(right_base_ff)) + offset;

   always_comb begin
      if (left_raw < 0)
         left_clamp = '0;
      else if (left_raw > $signed(CORR_BITS'(SPEED_MAX)))
         left_clamp = SPEED_MAX;
      else
         left_clamp = left_raw[SPEED_BITS-1:0];
      if (right_raw < 0)
         right_clamp = '0;
      else if (right_raw > $signed(CORR_BITS'(SPEED_MAX)))
         right_clamp = SPEED_MAX;
      else
         right_clamp = right_raw[SPEED_BITS-1:0];
   end

   always_comb begin
      if (!lost_ff)
         loss_run_in = '0;
      else if (loss_run_ff == LOSS_MAX)
         loss_run_in = LOSS_MAX;
      else
         loss_run_in = loss_run_ff + 1'b1;
   end

   // Control state, configuration and loop state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         acc_idx_ff     <= '0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         last_pos_ff    <= '0;
         loss_run_ff    <= '0;
         threshold_ff   <= THRESHOLD_RESET;
         gain_ff        <= GAIN_RESET;
         left_base_ff   <= LEFT_BASE_RESET;
         right_base_ff  <= RIGHT_BASE_RESET;
         search_spin_ff <= SEARCH_SPIN_RESET;
         min_signal_ff  <= MIN_SIGNAL_RESET;
         min_active_ff  <= MIN_ACTIVE_RESET;
         lost_limit_ff  <= LOST_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         if (accept) acc_idx_ff <= '0;
         else if (state_ff == ST_ACCUM) acc_idx_ff <= acc_idx_ff + 1'b1;
         if (state_ff == ST_SETUP) div_cnt_ff <= '0;
         else if (state_ff == ST_DIVIDE) div_cnt_ff <= div_cnt_ff + 1'b1;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            loss_run_ff  <= loss_run_in;
            if (!lost_ff) last_pos_ff <= pos_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               REG_THRESHOLD:   threshold_ff   <= csr_wdata[SAMPLE_BITS-1:0];
               REG_GAIN:        gain_ff        <= csr_wdata[SPEED_BITS-1:0];
               REG_LEFT_BASE:   left_base_ff   <= csr_wdata[SPEED_BITS-1:0];
               REG_RIGHT_BASE:  right_base_ff  <= csr_wdata[SPEED_BITS-1:0];
               REG_SEARCH_SPIN: search_spin_ff <= csr_wdata[SPEED_BITS-1:0];
               REG_MIN_SIGNAL:  min_signal_ff  <= csr_wdata[TOTAL_BITS-1:0];
               REG_MIN_ACTIVE:  min_active_ff  <= csr_wdata[COUNT_BITS-1:0];
               REG_LOST_LIMIT:  lost_limit_ff  <= csr_wdata[COUNT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         samp_ff[0] <= req_sample_0;
         samp_ff[1] <= req_sample_1;
         samp_ff[2] <= req_sample_2;
         samp_ff[3] <= req_sample_3;
         samp_ff[4] <= req_sample_4;
         samp_ff[5] <= req_sample_5;
         samp_ff[6] <= req_sample_6;
         samp_ff[7] <= req_sample_7;
         total_ff   <= '0;
         wsum_ff    <= '0;
         active_ff  <= '0;
      end else if (state_ff == ST_ACCUM) begin
         for (int i = 0; i < SENSOR_COUNT - 1; i++) samp_ff[i] <= samp_ff[i+1];
         total_ff  <= total_ff + TOTAL_BITS'(head_v);
         wsum_ff   <= wsum_ff + head_prod;
         active_ff <= active_ff + COUNT_BITS'(head_active);
      end

      if (state_ff == ST_SETUP) begin
         lost_ff <= total_low;
         if (total_low || total_ff == '0) begin
            sign_ff <= 1'b0;
            dq_ff   <= '0;
            rem_ff  <= '0;
         end else begin
            sign_ff <= wsum_ff[WSUM_BITS-1];
            rem_ff  <= TOTAL_BITS'(wsum_abs[MAG_BITS-1:QUOT_BITS]);
            dq_ff   <= wsum_abs[QUOT_BITS-1:0];
         end
      end else if (state_ff == ST_DIVIDE) begin
         rem_ff <= trial_ge ? TOTAL_BITS'(trial - {1'b0, total_ff}) : trial[TOTAL_BITS-1:0];
         dq_ff  <= {dq_ff[QUOT_BITS-2:0], trial_ge};
      end

      if (state_ff == ST_SCALE) begin
         pos_ff  <= pos_new;
         corr_ff <= CORR_BITS'(scaled_adj >>> 4);
      end

      if (rsp_load) begin
         left_ff       <= left_clamp;
         right_ff      <= right_clamp;
         position_ff   <= pos_ff;
         line_lost_ff  <= lost_ff;
         active_out_ff <= active_ff;
         at_int_ff     <= active_ff >= min_active_ff;
         line_ended_ff <= loss_run_in >= lost_limit_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_speed      = left_ff;
   assign rsp_right_speed     = right_ff;
   assign rsp_position        = position_ff;
   assign rsp_line_lost       = line_lost_ff;
   assign rsp_active_count    = active_out_ff;
   assign rsp_at_intersection = at_int_ff;
   assign rsp_line_ended      = line_ended_ff;

endmodule

// File: hdl/lfs_checker.sv
// Port-level checks for the line follower steering block, bound to the top level.
// Depends on lfs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [lfs_pkg::SPEED_BITS-1:0]      rsp_left_speed,
   input logic [lfs_pkg::SPEED_BITS-1:0]      rsp_right_speed,
   input logic signed [lfs_pkg::POS_BITS-1:0] rsp_position,
   input logic                                rsp_line_lost
);

   import lfs_pkg::*;

   logic [2*SPEED_BITS+POS_BITS-1:0] rsp_payload;

   assign rsp_payload = {rsp_left_speed, rsp_right_speed, rsp_position};

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `ASSERT_IMPLY(a_lost_center, clock, reset, rsp_valid && rsp_line_lost, rsp_position == 0)
   `ASSERT_IMPLY(a_pos_range, clock, reset, rsp_valid, rsp_position >= -350 && rsp_position <= 350)
   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLY(a_result_after_work, clock, reset, $rose(rsp_valid), !$past(req_ready))

endmodule

bind line_follow_steering lfs_checker u_lfs_checker (.*);
